### src/osvm_pkg.sv
// Package for the oversampled supply voltage meter.
// Holds the microcode format, the control program, status types and constants.
// No dependencies; every other file imports it.
package osvm_pkg;

    localparam int unsigned SUM_W   = 14;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned CODE_W  = 12;
    localparam int unsigned MV_W    = 16;
    localparam int unsigned PROD_W  = MV_W + CODE_W;
    localparam int unsigned BIT_W   = 5;
    localparam int unsigned STEP_W  = 2;

    localparam logic [MV_W-1:0]   DEFAULT_REF_MV   = 16'd1100;
    localparam logic [MV_W-1:0]   REF_DEFAULT_MARK = 16'hFFFF;
    localparam logic [MV_W-1:0]   KNOWN_VCC_RESET  = 16'd5000;
    localparam logic [CODE_W-1:0] CODE_FULL_SCALE  = 12'd4095;
    localparam logic [CNT_W-1:0]  LAST_SAMPLE      = 4'd15;
    localparam logic [BIT_W-1:0]  DIV_LAST_BIT     = 5'(PROD_W - 1);

    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_LOAD_REF = 1'b1;

    localparam logic KIND_MEASURE   = 1'b0;
    localparam logic KIND_CALIBRATE = 1'b1;

    localparam logic REG_CALIBRATE_MODE = 1'b0;
    localparam logic REG_KNOWN_VCC      = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT   = 2'd0;
    localparam step_t STEP_MUL    = 2'd1;
    localparam step_t STEP_DIV    = 2'd2;
    localparam step_t STEP_RESULT = 2'd3;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_BLOCK_DONE,
        COND_DIV_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  wait_in;
        logic  ld_div;
        logic  div_step;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    typedef struct packed {
        logic block_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic ctl_word_t rom_word(input step_t step);
        ctl_word_t w;
        w = '{wait_in: 1'b0, ld_div: 1'b0, div_step: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: STEP_WAIT};
        case (step)
            STEP_WAIT:
            begin
                w.wait_in = 1'b1;
                w.cond    = COND_BLOCK_DONE;
                w.target  = STEP_MUL;
            end
            STEP_MUL:
            begin
                w.ld_div = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_DIV;
            end
            STEP_DIV:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_DONE;
                w.target   = STEP_RESULT;
            end
            STEP_RESULT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

### src/osvm_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on osvm_pkg.
module osvm_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  osvm_pkg::dp_status_t status,
    output osvm_pkg::ctl_word_t  ctl
);
    import osvm_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    assign ctl = rom_word(step_reg);

    always_comb
    begin
        case (ctl.cond)
            COND_ALWAYS:     take_jump = 1'b1;
            COND_BLOCK_DONE: take_jump = status.block_done;
            COND_DIV_DONE:   take_jump = status.div_done;
            COND_OUT_FREE:   take_jump = status.out_free;
            default:         take_jump = 1'b1;
        endcase
        step_next = take_jump ? ctl.target : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### src/osvm_dp.sv
// Datapath: sample accumulator, reference register, multiplier, serial divider
// and output register. Driven by the control word from osvm_seq; uses osvm_pkg.
module osvm_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  osvm_pkg::ctl_word_t  ctl,
    output osvm_pkg::dp_status_t status,
    input  logic                 calibrate_mode,
    input  logic [15:0]          known_vcc_mv,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);
    import osvm_pkg::*;

    logic                in_fire;
    logic [9:0]          adc_sample;
    logic [MV_W-1:0]     ref_value_mv;
    logic [SUM_W-1:0]    sum_add;

    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MV_W-1:0]     ref_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                kind_reg;
    logic [CODE_W-1:0]   divisor_reg;
    logic [PROD_W-1:0]   dq_reg;
    logic [CODE_W-1:0]   rem_reg;
    logic [BIT_W-1:0]    bit_reg;

    logic [MV_W-1:0]     mul_a;
    logic [CODE_W-1:0]   mul_b;
    logic [PROD_W-1:0]   product;
    logic [CODE_W:0]     trial;
    logic                trial_ge;

    logic                sat;
    logic [MV_W-1:0]     result_mv;
    logic                result_err;
    logic                emit_fire;

    logic                m_valid_reg;
    logic [MV_W-1:0]     m_mv_reg;
    logic [CODE_W-1:0]   m_code_reg;
    logic                m_err_reg;
    logic                m_kind_reg;

    assign adc_sample   = s_tdata[9:0];
    assign ref_value_mv = s_tdata[25:10];
    assign s_tready     = ctl.wait_in;
    assign in_fire      = s_tvalid && s_tready;
    assign sum_add      = sum_reg + SUM_W'(adc_sample);

    assign status.block_done = in_fire && (s_tuser == REQ_SAMPLE) && (cnt_reg == LAST_SAMPLE);
    assign status.div_done   = (bit_reg == '0);
    assign status.out_free   = !m_valid_reg || m_tready;

    assign mul_a   = calibrate_mode ? known_vcc_mv : ref_reg;
    assign mul_b   = calibrate_mode ? code_reg : CODE_FULL_SCALE;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign trial    = {rem_reg, dq_reg[PROD_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    assign sat        = |dq_reg[PROD_W-1:MV_W];
    assign result_mv  = sat ? REF_DEFAULT_MARK : dq_reg[MV_W-1:0];
    assign result_err = sat || (code_reg == '0);
    assign emit_fire  = ctl.emit && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ref_reg <= DEFAULT_REF_MV;
        end
        else
        begin
            if (in_fire)
            begin
                if (s_tuser == REQ_LOAD_REF)
                begin
                    ref_reg <= (ref_value_mv == REF_DEFAULT_MARK) ? DEFAULT_REF_MV
                                                                  : ref_value_mv;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= (cnt_reg == LAST_SAMPLE) ? '0 : sum_add;
                end
            end
            else if (emit_fire && (kind_reg == KIND_CALIBRATE))
            begin
                ref_reg <= result_mv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.block_done)
        begin
            code_reg <= sum_add[SUM_W-1:2];
        end
        if (ctl.ld_div)
        begin
            dq_reg      <= product;
            divisor_reg <= calibrate_mode ? CODE_FULL_SCALE : code_reg;
            rem_reg     <= '0;
            bit_reg     <= DIV_LAST_BIT;
            kind_reg    <= calibrate_mode ? KIND_CALIBRATE : KIND_MEASURE;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= trial_ge ? CODE_W'(trial - {1'b0, divisor_reg}) : trial[CODE_W-1:0];
            dq_reg  <= {dq_reg[PROD_W-2:0], trial_ge};
            bit_reg <= bit_reg - 1'b1;
        end
        if (emit_fire)
        begin
            m_mv_reg   <= result_mv;
            m_code_reg <= code_reg;
            m_err_reg  <= result_err;
            m_kind_reg <= kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_err_reg, m_code_reg, m_mv_reg};
    assign m_tuser  = m_kind_reg;

endmodule

### src/oversampled_supply_voltage_meter.sv
// Top level of the oversampled supply voltage meter.
// Holds the APB register file and connects osvm_seq and osvm_dp; uses osvm_pkg.
//
// Input stream (s_*): one transaction per ADC bandgap conversion or reference
// load, selected by s_tuser. A reference load or a sample that does not
// complete a block of 16 gives no result. The 16th sample starts the
// computation: a multiply step, a one-bit-per-cycle restoring divider and a
// result step that writes the output register. While computing, s_tready is
// low; it returns high once the result sits in the output register, which
// holds it until m_tready takes it. If the receiver still holds a previous
// result, the sequencer waits in its last step.
// Reset clears the sample sum and count, loads 1100 mV as the reference, sets
// measure mode and a known supply of 5000 mV, and empties the output register.
// APB: calibrate_mode at address 0, known_vcc_mv at address 4; pready is tied
// high and writes take effect at the access cycle.
module oversampled_supply_voltage_meter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] adc_sample, [25:10] ref_value_mv, rest zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] result_mv, [27:16] oversampled_code, [28] error_flag
    output logic        m_tuser,   // [0] result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import osvm_pkg::*;

    logic            mode_reg;
    logic [MV_W-1:0] known_reg;
    logic            cfg_write;
    ctl_word_t       ctl;
    dp_status_t      status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_KNOWN_VCC) ? {16'd0, known_reg} : {31'd0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            known_reg <= KNOWN_VCC_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CALIBRATE_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                known_reg <= pwdata[MV_W-1:0];
            end
        end
    end

    osvm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    osvm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .calibrate_mode (mode_reg),
        .known_vcc_mv   (known_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule
